@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RSI stream block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WRSI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wilder_rsi_stream: assertion failed");

// next-cycle implication
`define WRSI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wilder_rsi_stream: assertion failed");

`endif

@@ sv/wrsi_pkg.sv @@
// ---------------------------------------------------------------------------
// RSI stream package
// Fixed widths and constants of the Wilder RSI block.
// ---------------------------------------------------------------------------
package wrsi_pkg;

   localparam int PERIOD_W    = 8;
   localparam int SEEN_W      = 9;
   localparam int IN_DATA_W   = 32;
   localparam int OUT_DATA_W  = 24;
   localparam int RSI_W       = 23;
   localparam int RSI_FRAC    = 16;
   localparam int SCALE_W     = 7;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 8'd1;
   localparam logic [SCALE_W-1:0]  RSI_SCALE    = 7'd100;
   localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;

endpackage

@@ sv/wrsi_div.sv @@
// ---------------------------------------------------------------------------
// RSI radix-2 divider
// Restoring divider, one quotient bit per cycle, dividend taken MSB first.
// ---------------------------------------------------------------------------
module wrsi_div #(
   parameter int NUM_W  = 71,
   parameter int DEN_W  = 49,
   parameter int QUO_W  = 48,
   parameter int STEP_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [DEN_W-1:0]  divisor,
   input  logic [STEP_W-1:0] steps,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [NUM_W-1:0]  dvd_ff;
   logic [DEN_W-1:0]  dsr_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  quo_ff;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/wilder_rsi_stream.sv @@
// ---------------------------------------------------------------------------
// Wilder RSI stream
// Relative strength index with Wilder smoothing over a stream of prices.
// ---------------------------------------------------------------------------
// Input words carry a price on req_tdata and a series start flag on
// req_tuser; each accepted word yields exactly one output word. rsp_tuser is
// set once warm-up is over and rsp_tdata then holds the RSI (0..100, 16
// fraction bits), otherwise rsp_tdata is zero.
// The smoothing period is written through csr_wr_en/csr_wr_data; the user must
// write it only while idle; the block does not enforce it. A write closes the
// open series, and zero is taken as one. A series start or an ordinary warm-up
// word goes via ST_EMIT to the output register; the word that ends warm-up
// first divides its gain and loss sums by the period, a smoothed word divides
// the new numerators by the period and then forms the ratio unless the average
// loss is zero. One shared divider does all these, one quotient bit per cycle.
// req_tready is low while a word is in work; one word at a time.
// A finished word waits in the output register while the receiver stalls;
// the next input word is taken meanwhile but held before its result.
// Reset is synchronous: period returns to 14 and no series is open.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wilder_rsi_stream #(
   parameter int PRICE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wrsi_pkg::IN_DATA_W-1:0]     req_tdata,   // price
   input  logic [0:0]                         req_tuser,   // start_req
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wrsi_pkg::OUT_DATA_W-1:0]    rsp_tdata,   // rsi_value, zero pad
   output logic [0:0]                         rsp_tuser,   // valid_res
   input  logic                               csr_wr_en,
   input  logic [wrsi_pkg::PERIOD_W-1:0]      csr_wr_data  // period
);

   import wrsi_pkg::*;

   localparam int PW      = (PRICE_BITS < IN_DATA_W) ? PRICE_BITS : IN_DATA_W;
   localparam int AVG_RAW = PRICE_BITS + FRAC_BITS;
   localparam int AVG_W   = (AVG_RAW < 64) ? AVG_RAW : 64;
   localparam int NUM_W   = (AVG_W + PERIOD_W < 64) ? AVG_W + PERIOD_W : 64;
   localparam int DEN_W   = (AVG_W + 1 < 64) ? AVG_W + 1 : 64;
   localparam int DIVN_W  = AVG_W + SCALE_W + RSI_FRAC;
   localparam int ALIGN   = DIVN_W - NUM_W;
   localparam int STEP_W  = $clog2(DIVN_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_G,
      ST_WT_G,
      ST_LD_L,
      ST_WT_L,
      ST_LD_R,
      ST_WT_R,
      ST_EMIT
   } state_type;

   state_type           state_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [SEEN_W-1:0]   seen_ff;
   logic                smooth_ff;
   logic [PW-1:0]       last_ff;
   logic [PW-1:0]       up_ff;
   logic [PW-1:0]       dn_ff;
   logic [AVG_W-1:0]    gain_ff;
   logic [AVG_W-1:0]    loss_ff;
   logic [RSI_W-1:0]    res_rsi_ff;
   logic                res_ok_ff;
   logic                rsp_valid_ff;
   logic [RSI_W-1:0]    rsp_rsi_ff;
   logic                rsp_ok_ff;

   logic [PW-1:0]               price;
   logic                        start_req;
   logic [PW-1:0]               up_move;
   logic [PW-1:0]               dn_move;
   logic [PERIOD_W-1:0]         pm1;
   logic [AVG_W-1:0]            src_avg;
   logic [PW-1:0]               src_move;
   logic [AVG_W+PERIOD_W-1:0]   smooth_prod;
   logic [NUM_W-1:0]            num_in;
   logic [AVG_W+SCALE_W-1:0]    rsi_prod;
   logic [DEN_W-1:0]            dsum;
   logic                        rsi_full;
   logic                        accept;
   logic                        div_start;
   logic                        div_done;
   logic [DIVN_W-1:0]           div_dividend;
   logic [DEN_W-1:0]            div_divisor;
   logic [STEP_W-1:0]           div_steps;
   logic [AVG_W-1:0]            div_quotient;

   assign price     = req_tdata[PW-1:0];
   assign start_req = req_tuser[0];
   assign up_move   = (price > last_ff) ? price - last_ff : '0;
   assign dn_move   = (price < last_ff) ? last_ff - price : '0;
   assign pm1       = period_ff - 1'b1;

   assign src_avg     = (state_ff == ST_LD_L) ? loss_ff : gain_ff;
   assign src_move    = (state_ff == ST_LD_L) ? dn_ff : up_ff;
   assign smooth_prod = src_avg * pm1;
   assign num_in      = smooth_ff
                        ? NUM_W'(smooth_prod) + (NUM_W'(src_move) << FRAC_BITS)
                        : NUM_W'(src_avg) << FRAC_BITS;

   assign rsi_prod = gain_ff * RSI_SCALE;
   assign dsum     = DEN_W'(gain_ff) + DEN_W'(loss_ff);
   assign rsi_full = (loss_ff == '0) || (dsum == '0);

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign div_start    = (state_ff == ST_LD_G) || (state_ff == ST_LD_L) ||
                         ((state_ff == ST_LD_R) && !rsi_full);
   assign div_dividend = (state_ff == ST_LD_R) ? DIVN_W'(rsi_prod) << RSI_FRAC
                                               : DIVN_W'(num_in) << ALIGN;
   assign div_divisor  = (state_ff == ST_LD_R) ? dsum : DEN_W'(period_ff);
   assign div_steps    = (state_ff == ST_LD_R) ? STEP_W'(DIVN_W) : STEP_W'(NUM_W);

   wrsi_div #(
      .NUM_W  (DIVN_W),
      .DEN_W  (DEN_W),
      .QUO_W  (AVG_W),
      .STEP_W (STEP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= (csr_wr_data == '0) ? PERIOD_MIN : csr_wr_data;
            seen_ff   <= '0;
         end
         if (rsp_tready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_ff    <= price;
                  up_ff      <= up_move;
                  dn_ff      <= dn_move;
                  res_rsi_ff <= '0;
                  res_ok_ff  <= 1'b0;
                  if (start_req || seen_ff == '0) begin
                     gain_ff  <= '0;
                     loss_ff  <= '0;
                     seen_ff  <= SEEN_W'(1);
                     state_ff <= ST_EMIT;
                  end else if (seen_ff <= SEEN_W'(period_ff)) begin
                     gain_ff   <= gain_ff + AVG_W'(up_move);
                     loss_ff   <= loss_ff + AVG_W'(dn_move);
                     seen_ff   <= seen_ff + 1'b1;
                     smooth_ff <= 1'b0;
                     state_ff  <= (seen_ff == SEEN_W'(period_ff)) ? ST_LD_G : ST_EMIT;
                  end else begin
                     smooth_ff <= 1'b1;
                     state_ff  <= ST_LD_G;
                  end
               end
            end
            ST_LD_G: begin
               state_ff <= ST_WT_G;
            end
            ST_WT_G: begin
               if (div_done) begin
                  gain_ff  <= div_quotient;
                  state_ff <= ST_LD_L;
               end
            end
            ST_LD_L: begin
               state_ff <= ST_WT_L;
            end
            ST_WT_L: begin
               if (div_done) begin
                  loss_ff  <= div_quotient;
                  state_ff <= smooth_ff ? ST_LD_R : ST_EMIT;
               end
            end
            ST_LD_R: begin
               res_ok_ff <= 1'b1;
               if (rsi_full) begin
                  res_rsi_ff <= RSI_FULL;
                  state_ff   <= ST_EMIT;
               end else begin
                  state_ff <= ST_WT_R;
               end
            end
            ST_WT_R: begin
               if (div_done) begin
                  res_rsi_ff <= div_quotient[RSI_W-1:0];
                  state_ff   <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_rsi_ff   <= res_rsi_ff;
                  rsp_ok_ff    <= res_ok_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_DATA_W-RSI_W){1'b0}}, rsp_rsi_ff};
   assign rsp_tuser  = rsp_ok_ff;

   `WRSI_ASSERT_IMP(a_invalid_word_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   `WRSI_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `WRSI_ASSERT_IMP(a_seen_bounded, clock, reset, 1'b1, seen_ff <= SEEN_W'(period_ff) + 1'b1)

endmodule

@@ sim/rsi_checker.sv @@
// ---------------------------------------------------------------------------
// RSI stream checker
// Watches the price and RSI channels and the period register of the Wilder
// RSI block. Keeps its own copy of the smoothing state, works out the RSI
// word each accepted price should give, and compares every returned word
// in order against it.
// ---------------------------------------------------------------------------
module rsi_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [wrsi_pkg::IN_DATA_W-1:0]  req_tdata,   // price
   input  logic [0:0]                      req_tuser,   // start_req
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [wrsi_pkg::OUT_DATA_W-1:0] rsp_tdata,   // rsi_value, zero pad
   input  logic [0:0]                      rsp_tuser,   // valid_res
   input  logic                            csr_wr_en,
   input  logic [wrsi_pkg::PERIOD_W-1:0]   csr_wr_data, // period
   output int                              fail_count,
   output int                              awaiting
);

   import wrsi_pkg::*;

   typedef struct packed {
      logic [OUT_DATA_W-1:0] rsi_word;
      logic [0:0]            ready_flag;
   } rsi_result_type;

   rsi_result_type       rsi_due_q[$];
   logic [PERIOD_W-1:0]  window;
   logic [SEEN_W-1:0]    taken;
   logic [IN_DATA_W-1:0] prior_price;
   logic [63:0]          mean_gain;
   logic [63:0]          mean_loss;
   int                   errors;

   function automatic rsi_result_type advance_rsi(logic [IN_DATA_W-1:0] price, logic opens);
      logic [63:0] w;
      logic [63:0] up;
      logic [63:0] down;
      logic [63:0] total;
      logic [95:0] scaled;
      rsi_result_type r;
      r = '0;
      w = 64'(window);
      if (opens || taken == '0) begin
         prior_price = price;
         mean_gain   = '0;
         mean_loss   = '0;
         taken       = SEEN_W'(1);
         return r;
      end
      up   = (price > prior_price) ? 64'(price - prior_price) : 64'd0;
      down = (price < prior_price) ? 64'(prior_price - price) : 64'd0;
      prior_price = price;
      if (taken <= SEEN_W'(window)) begin
         mean_gain = mean_gain + up;
         mean_loss = mean_loss + down;
         if (taken == SEEN_W'(window)) begin
            mean_gain = (mean_gain << FRAC_BITS) / w;
            mean_loss = (mean_loss << FRAC_BITS) / w;
         end
         taken = taken + SEEN_W'(1);
         return r;
      end
      mean_gain = (mean_gain * (w - 64'd1) + (up << FRAC_BITS)) / w;
      mean_loss = (mean_loss * (w - 64'd1) + (down << FRAC_BITS)) / w;
      r.ready_flag = 1'b1;
      total = mean_gain + mean_loss;
      if (mean_loss == '0 || total == '0) begin
         r.rsi_word = OUT_DATA_W'(RSI_FULL);
      end else begin
         scaled = (96'(mean_gain) * 96'(RSI_FULL)) / 96'(total);
         r.rsi_word = OUT_DATA_W'(scaled[RSI_W-1:0]);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsi_result_type want;
      if (reset) begin
         window      = PERIOD_RESET;
         taken       = '0;
         prior_price = '0;
         mean_gain   = '0;
         mean_loss   = '0;
         errors      = 0;
         rsi_due_q.delete();
      end else begin
         if (csr_wr_en) begin
            window = (csr_wr_data == '0) ? PERIOD_MIN : csr_wr_data;
            taken  = '0;
         end
         if (req_tvalid && req_tready) begin
            rsi_due_q.push_back(advance_rsi(req_tdata, req_tuser[0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsi_due_q.size() == 0) begin
               errors++;
               $display("%0t unexpected rsi word: expected none actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = rsi_due_q.pop_front();
               if (rsp_tdata !== want.rsi_word) begin
                  errors++;
                  $display("%0t rsi_value mismatch: expected %h actual %h",
                           $time, want.rsi_word, rsp_tdata);
               end
               if (rsp_tuser !== want.ready_flag) begin
                  errors++;
                  $display("%0t valid_res mismatch: expected %b actual %b",
                           $time, want.ready_flag, rsp_tuser);
               end
            end
         end
      end
      fail_count <= errors;
      awaiting   <= rsi_due_q.size();
   end

endmodule

@@ sim/wilder_rsi_stream_test.sv @@
// ---------------------------------------------------------------------------
// Wilder RSI stream regression
// Drives price series through the RSI block under several smoothing periods,
// with random gaps and stalls on both channels and one long output stall,
// and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module wilder_rsi_stream_test;
   import wrsi_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata   = '0;   // price
   logic [0:0]            req_tuser   = '0;   // start_req
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;          // rsi_value, zero pad
   logic [0:0]            rsp_tuser;          // valid_res
   logic                  csr_wr_en   = 1'b0;
   logic [PERIOD_W-1:0]   csr_wr_data = '0;   // period

   int   fail_count;
   int   awaiting;
   logic calm    = 1'b0;
   logic squeeze = 1'b0;

   wilder_rsi_stream DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rsi_checker rsi_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .awaiting    (awaiting)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_word(input logic [IN_DATA_W-1:0] price, input logic opens);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= price;
      req_tuser  <= opens;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic write_window(input logic [PERIOD_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [IN_DATA_W-1:0] next_price(logic [IN_DATA_W-1:0] prev);
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         4:       return prev;
         default: return prev + $urandom_range(0, 4000) - 32'd2000;
      endcase
   endfunction

   task automatic run_phase(input logic [PERIOD_W-1:0] win, input int budget,
                            input int pause_at, input int squeeze_at);
      int                   done;
      int                   len;
      int                   k;
      logic [IN_DATA_W-1:0] price;
      drain();
      write_window(win);
      done  = 0;
      price = $urandom;
      while (done < budget) begin
         if ($urandom_range(0, 9) < 8) len = int'(win) + 1 + $urandom_range(0, 40);
         else len = $urandom_range(1, int'(win) + 1);
         for (k = 0; k < len; k++) begin
            price = next_price(price);
            if (done == pause_at) drain();
            if (done == squeeze_at) squeeze = 1'b1;
            send_word(price, (k == 0) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 39) == 0));
            done++;
         end
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (squeeze) begin
            rsp_tready <= 1'b0;
            repeat (500) @(posedge clock);
            squeeze = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("wilder_rsi_stream regression: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no series open after reset, extreme moves in warm-up
      send_word(32'd100, 1'b0);
      send_word('1, 1'b0);
      send_word('0, 1'b0);

      drain();
      write_window(8'd2);
      send_word(32'd5, 1'b0);
      send_word(32'd10, 1'b0);
      send_word(32'd20, 1'b0);
      send_word(32'd30, 1'b0);
      send_word(32'd30, 1'b0);
      send_word('1, 1'b0);
      send_word('0, 1'b0);
      send_word('0, 1'b0);
      // falling only, then flat only
      send_word(32'd50, 1'b1);
      send_word(32'd40, 1'b0);
      send_word(32'd30, 1'b0);
      send_word(32'd20, 1'b0);
      send_word(32'd7, 1'b1);
      send_word(32'd7, 1'b0);
      send_word(32'd7, 1'b0);
      send_word(32'd7, 1'b0);

      // zero period, written with a series open
      drain();
      write_window(8'd0);
      send_word(32'd9, 1'b0);
      send_word(32'd12, 1'b0);
      send_word(32'd3, 1'b0);

      run_phase(8'd3, 62, -1, -1);
      run_phase(8'd255, 270, -1, -1);
      run_phase(8'd1, 62, -1, 20);
      run_phase(8'd7, 62, 30, -1);
      run_phase(PERIOD_W'($urandom_range(2, 30)), 62, -1, -1);
      run_phase(8'd14, 62, -1, -1);
      run_phase(PERIOD_W'($urandom_range(2, 60)), 62, -1, -1);
      run_phase(8'd40, 62, -1, -1);
      calm = 1'b1;
      run_phase(8'd5, 62, -1, -1);

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("wilder_rsi_stream regression: pass");
      end else begin
         $display("wilder_rsi_stream regression: fail");
      end
      $finish;
   end

endmodule
